@@ hdl/pid_controller_step_assert.svh @@
// ----------------------------------------------------------------------------
// PID controller step - assertion macros
// Concurrent assertion shorthands clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_STEP_ASSERT_SVH
`define PID_CONTROLLER_STEP_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define PCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pcs_pkg.sv @@
// ----------------------------------------------------------------------------
// PID controller step - package
// Widths, register indexes, sequencer states and fixed limits.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 24;
    localparam int ACC_W     = 48;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SUM_W     = 64;
    localparam int DIV_W     = 64;
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_STEPS = DIV_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] PERIOD_RESET = 32'd167772;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic [DIV_W-1:0] D_LIMIT = 64'h1000_0000_0000_0000;

    localparam logic signed [SUM_W-1:0] DRIVE_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [SUM_W-1:0] DRIVE_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN     = 2'd0,
        CFG_INT_GAIN      = 2'd1,
        CFG_DERIV_GAIN    = 2'd2,
        CFG_SAMPLE_PERIOD = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INC,
        S_PROP,
        S_ILO,
        S_IHI,
        S_DIFF,
        S_DSETUP,
        S_DIV,
        S_DFIN,
        S_WRITE
    } state_t;

endpackage

@@ hdl/pcs_if.sv @@
// ----------------------------------------------------------------------------
// PID controller step - channel interfaces
// Valid/ready channels for configuration writes, error samples and drive results.
// ----------------------------------------------------------------------------
interface pcs_cfg_if;
    import pcs_pkg::*;

    logic              valid;
    logic              ready;
    cfg_index_t        index;
    logic [DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface pcs_in_if;
    import pcs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] error_value;

    modport source (output valid, output error_value, input ready);
    modport sink   (input valid, input error_value, output ready);
endinterface

interface pcs_out_if;
    import pcs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive_value;
    logic                     period_invalid;

    modport source (output valid, output drive_value, output period_invalid, input ready);
    modport sink   (input valid, input drive_value, input period_invalid, output ready);
endinterface

@@ hdl/pid_controller_step.sv @@
// ----------------------------------------------------------------------------
// PID controller step - top level
// Positional fixed-point PID: one error sample in, one saturated drive out.
// ----------------------------------------------------------------------------
// Each accepted error sample (Q8.24) produces one drive transaction (Q8.24).
// With a nonzero sample period one 33x33 multiplier is shared over five
// products (e*T, Kp*e, Ki*I low half, Ki*I high half, Kd*(e - e_prev)), a
// setup state prepares the divider, then a restoring divider retires two
// quotient bits per cycle to form the derivative term, and a finishing state
// completes the sum before the write state loads the output register once it
// is free. The next sample is taken only once the sequencer is back in idle.
// With a zero period the result (drive 0, period_invalid 1) is loaded in the
// write state that follows acceptance, and the integral and previous error
// are kept. sample.ready is high only while the sequencer is idle; a finished
// result waits in the output register while the next sample is taken.
// Configuration writes are taken every cycle and belong in idle time.
// ----------------------------------------------------------------------------
module pid_controller_step (
    input  logic      clk,
    input  logic      rst_n,
    pcs_cfg_if.sink   cfg,
    pcs_in_if.sink    sample,
    pcs_out_if.source result
);
    import pcs_pkg::*;

    `include "pid_controller_step_assert.svh"

    // Configuration registers
    logic signed [DATA_W-1:0] prop_gain_reg;
    logic signed [DATA_W-1:0] int_gain_reg;
    logic signed [DATA_W-1:0] deriv_gain_reg;
    logic        [DATA_W-1:0] period_reg;

    // Controller state
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [DATA_W-1:0] last_error_reg, last_error_next;

    // Sequencer
    state_t                   state_reg, state_next;
    logic [DIV_CNT_W-1:0]     cnt_reg, cnt_next;

    // Working registers
    logic signed [DATA_W-1:0] error_reg, error_next;
    logic                     invalid_reg, invalid_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [DATA_W-1:0]        rem_reg, rem_next;
    logic [DIV_W-1:0]         dq_reg, dq_next;
    logic                     neg_reg, neg_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_drive_reg, out_drive_next;
    logic                     out_invalid_reg, out_invalid_next;

    // Shared multiplier
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_prod;

    logic                     accept;
    logic                     load_out;

    assign accept = sample.valid && sample.ready;
    assign cfg.ready = 1'b1;

    assign result.valid          = out_valid_reg;
    assign result.drive_value    = out_drive_reg;
    assign result.period_invalid = out_invalid_reg;

    // ------------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= '0;
            int_gain_reg   <= '0;
            deriv_gain_reg <= '0;
            period_reg     <= PERIOD_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_PROP_GAIN:     prop_gain_reg  <= cfg.data;
                CFG_INT_GAIN:      int_gain_reg   <= cfg.data;
                CFG_DERIV_GAIN:    deriv_gain_reg <= cfg.data;
                CFG_SAMPLE_PERIOD: period_reg     <= cfg.data;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    // A zero period skips all arithmetic and goes straight to output.
                    state_next = (period_reg == '0) ? S_WRITE : S_INC;
                end
            end
            S_INC:    state_next = S_PROP;
            S_PROP:   state_next = S_ILO;
            S_ILO:    state_next = S_IHI;
            S_IHI:    state_next = S_DIFF;
            S_DIFF:   state_next = S_DSETUP;
            S_DSETUP: state_next = S_DIV;
            S_DIV:
            begin
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DFIN;
                end
            end
            S_DFIN:   state_next = S_WRITE;
            S_WRITE:
            begin
                // Hold until the output register is free or being drained.
                if (!out_valid_reg || result.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer: outputs (handshake and multiplier operand selection)
    // ------------------------------------------------------------------------
    always_comb
    begin
        sample.ready = 1'b0;
        load_out     = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                sample.ready = 1'b1;
            end
            S_INC:
            begin
                // e * T, T taken as unsigned
                mul_a = MUL_W'(error_reg);
                mul_b = $signed({1'b0, period_reg});
            end
            S_PROP:
            begin
                mul_a = MUL_W'(prop_gain_reg);
                mul_b = MUL_W'(error_reg);
            end
            S_ILO:
            begin
                // Low 24 bits of the integral, unsigned
                mul_a = MUL_W'(int_gain_reg);
                mul_b = MUL_W'($signed({1'b0, acc_reg[FRAC_W-1:0]}));
            end
            S_IHI:
            begin
                // Upper bits of the integral, signed, already weighted by 2^24
                mul_a = MUL_W'(int_gain_reg);
                mul_b = MUL_W'($signed(acc_reg[ACC_W-1:FRAC_W]));
            end
            S_DIFF:
            begin
                mul_a = MUL_W'(deriv_gain_reg);
                mul_b = MUL_W'(error_reg) - MUL_W'(last_error_reg);
            end
            S_WRITE:
            begin
                load_out = !out_valid_reg || result.ready;
            end
            default:
            begin
                sample.ready = 1'b0;
            end
        endcase
    end

    assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // ------------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------------
    logic signed [ACC_W+1:0]  acc_sum;
    logic [DIV_W-1:0]         mag;
    logic [DIV_W-1:0]         q_lim;
    logic [DATA_W:0]          div_trial;
    logic [DATA_W-1:0]        div_rem;
    logic [DIV_W-1:0]         div_dq;
    logic                     div_bit;

    always_comb
    begin
        acc_next        = acc_reg;
        last_error_next = last_error_reg;
        error_next      = error_reg;
        invalid_next    = invalid_reg;
        sum_next        = sum_reg;
        rem_next        = rem_reg;
        dq_next         = dq_reg;
        neg_next        = neg_reg;
        cnt_next        = cnt_reg;

        acc_sum = (ACC_W+2)'(acc_reg) + (ACC_W+2)'(prod_reg >>> FRAC_W);
        mag     = prod_reg[PROD_W-1] ? DIV_W'(-prod_reg) : DIV_W'(prod_reg);
        q_lim   = (dq_reg > D_LIMIT) ? D_LIMIT : dq_reg;

        // Two restoring division steps per cycle
        div_rem = rem_reg;
        div_dq  = dq_reg;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            div_trial = {div_rem, div_dq[DIV_W-1]};
            if (div_trial >= {1'b0, period_reg})
            begin
                div_trial = div_trial - {1'b0, period_reg};
                div_bit   = 1'b1;
            end
            else
            begin
                div_bit   = 1'b0;
            end
            div_rem = div_trial[DATA_W-1:0];
            div_dq  = {div_dq[DIV_W-2:0], div_bit};
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    error_next   = sample.error_value;
                    invalid_next = (period_reg == '0);
                end
            end
            S_PROP:
            begin
                // Add floor(e*T / 2^24) and clamp to the 48-bit range
                if (acc_sum > (ACC_W+2)'(ACC_MAX))
                begin
                    acc_next = ACC_MAX;
                end
                else if (acc_sum < (ACC_W+2)'(ACC_MIN))
                begin
                    acc_next = ACC_MIN;
                end
                else
                begin
                    acc_next = ACC_W'(acc_sum);
                end
            end
            S_ILO:
            begin
                // Proportional term
                sum_next = SUM_W'(prod_reg >>> FRAC_W);
            end
            S_IHI:
            begin
                sum_next = sum_reg + SUM_W'(prod_reg >>> FRAC_W);
            end
            S_DIFF:
            begin
                sum_next        = sum_reg + SUM_W'(prod_reg);
                last_error_next = error_reg;
            end
            S_DSETUP:
            begin
                // Divide magnitudes, restore the sign at the end (truncation toward zero)
                neg_next = prod_reg[PROD_W-1];
                dq_next  = mag;
                rem_next = '0;
                cnt_next = '0;
            end
            S_DIV:
            begin
                rem_next = div_rem;
                dq_next  = div_dq;
                cnt_next = cnt_reg + 1'b1;
            end
            S_DFIN:
            begin
                sum_next = neg_reg ? sum_reg - $signed(q_lim) : sum_reg + $signed(q_lim);
            end
            default:
            begin
                sum_next = sum_reg;
            end
        endcase
    end

    // Output register load and drain
    always_comb
    begin
        out_valid_next   = out_valid_reg && !result.ready;
        out_drive_next   = out_drive_reg;
        out_invalid_next = out_invalid_reg;
        if (load_out)
        begin
            out_valid_next   = 1'b1;
            out_invalid_next = invalid_reg;
            if (invalid_reg)
            begin
                out_drive_next = '0;
            end
            else if (sum_reg > DRIVE_MAX)
            begin
                out_drive_next = DATA_W'(DRIVE_MAX);
            end
            else if (sum_reg < DRIVE_MIN)
            begin
                out_drive_next = DATA_W'(DRIVE_MIN);
            end
            else
            begin
                out_drive_next = DATA_W'(sum_reg);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Control and controller state registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            acc_reg        <= '0;
            last_error_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            acc_reg        <= acc_next;
            last_error_reg <= last_error_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        error_reg       <= error_next;
        invalid_reg     <= invalid_next;
        prod_reg        <= mul_prod;
        sum_reg         <= sum_next;
        rem_reg         <= rem_next;
        dq_reg          <= dq_next;
        neg_reg         <= neg_next;
        out_drive_reg   <= out_drive_next;
        out_invalid_reg <= out_invalid_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `PCS_ASSERT_NEXT(a_zero_period_keeps_state, accept && (period_reg == '0), $stable(acc_reg) && $stable(last_error_reg), "zero period changed controller state")
    `PCS_ASSERT_SAME(a_div_rem_below_period, state_reg == S_DIV, rem_reg < period_reg, "divider remainder not below period")
    `PCS_ASSERT_SAME(a_invalid_drives_zero, result.valid && result.period_invalid, result.drive_value == '0, "invalid period result has nonzero drive")

endmodule
